[rtl/mrq_pkg.sv]
// Shared codes for the multilevel ready queue: action and status encodings.
// No dependencies; used by the core and its bound checker.
package mrq_pkg;

  typedef enum logic [1:0] {
    ACT_ENQ     = 2'd0,
    ACT_DEQ_TOP = 2'd1,
    ACT_DEQ_LVL = 2'd2,
    ACT_MOVE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_MISSING = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

endpackage

[rtl/multilevel_ready_queue_core.sv]
// Multilevel ready queue: one FIFO of process ids per priority level, kept as
// doubly linked lists in link memories and updated by a small sequencer.
// Depends on mrq_pkg for action and status codes.
//
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     action, process_id, priority_req, new_priority
// out_      output     out_valid / out_ready   process_id, status, all_empty
//
// After its transfer, a rejected item steps through S_CHECK and S_FIN, an enqueue
// through S_CHECK, S_APPEND and S_FIN, a dequeue through S_CHECK, S_UNLINK and
// S_FIN, and a move through S_CHECK, S_UNLINK, S_APPEND and S_FIN; the registered
// link memory reads and one list update per cycle set these steps.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new item is taken while it waits;
// a stalled output holds the sequencer in its last step until the register frees.
// Reset empties every level at once; the link memories are not cleared.
module multilevel_ready_queue_core #(
  parameter int NUM_LEVELS = 5,
  parameter int NUM_PROCS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [3:0] in_process_id,
  input  logic [2:0] in_priority_req,
  input  logic [2:0] in_new_priority,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_process_id,
  output mrq_pkg::status_t out_status,
  output logic       out_all_empty
);
  import mrq_pkg::*;

  localparam int PID_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int LV_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam logic [6:0] PID_LIM = 7'(NUM_PROCS);
  localparam logic [3:0] LV_LIM  = 4'(NUM_LEVELS);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_UNLINK, S_APPEND, S_FIN} state_t;

  state_t                  state_r;
  action_t                 act_r;
  logic [PID_W-1:0]        pid_r;
  logic [LV_W-1:0]         lv_r;
  logic [LV_W-1:0]         nlv_r;
  logic                    pid_ok_r;
  logic                    lv_ok_r;
  logic                    nlv_ok_r;
  logic [PID_W-1:0]        got_r;
  status_t                 st_r;
  logic [NUM_PROCS-1:0]    queued_r;
  logic [NUM_LEVELS-1:0]   nonempty_r;
  logic [PID_W-1:0]        head_r [NUM_LEVELS];
  logic [PID_W-1:0]        tail_r [NUM_LEVELS];
  logic                    out_valid_r;
  logic [3:0]              out_pid_r;
  status_t                 out_st_r;
  logic                    out_empty_r;

  // Link memories with registered read data.
  logic [PID_W-1:0]        next_mem [NUM_PROCS];
  logic [PID_W-1:0]        prev_mem [NUM_PROCS];
  logic [LV_W-1:0]         lvl_mem  [NUM_PROCS];
  logic [PID_W-1:0]        nx_rd_r;
  logic [PID_W-1:0]        pv_rd_r;
  logic [LV_W-1:0]         lv_rd_r;

  logic                    in_xfer;
  logic                    out_free;
  logic [LV_W-1:0]         top_lv;
  logic [LV_W-1:0]         deq_lv;
  logic [PID_W-1:0]        deq_head;
  logic [PID_W-1:0]        rd_addr;
  logic                    is_head;
  logic                    is_tail;
  logic                    next_we;
  logic [PID_W-1:0]        next_wa;
  logic [PID_W-1:0]        next_wd;
  logic                    prev_we;
  logic [PID_W-1:0]        prev_wa;
  logic [PID_W-1:0]        prev_wd;
  logic                    lvl_we;

  assign in_ready       = (state_r == S_IDLE);
  assign in_xfer        = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_process_id = out_pid_r;
  assign out_status     = out_st_r;
  assign out_all_empty  = out_empty_r;

  // Most urgent non-empty level: the lowest index wins.
  always_comb begin
    top_lv = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) top_lv = LV_W'(i);
    end
  end

  assign deq_lv   = (act_r == ACT_DEQ_TOP) ? top_lv : lv_r;
  assign deq_head = head_r[deq_lv];
  assign is_head  = (head_r[lv_r] == pid_r);
  assign is_tail  = (tail_r[lv_r] == pid_r);

  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = PID_W'(in_process_id);
      S_CHECK: rd_addr = (act_r == ACT_MOVE) ? pid_r : deq_head;
      default: rd_addr = pid_r;
    endcase
  end

  // Link writes. The tail's next link and the head's prev link are never
  // read, so an append touches only the old tail and the new entry.
  always_comb begin
    next_we = 1'b0;
    next_wa = pv_rd_r;
    next_wd = nx_rd_r;
    prev_we = 1'b0;
    prev_wa = nx_rd_r;
    prev_wd = pv_rd_r;
    lvl_we  = 1'b0;
    case (state_r)
      S_UNLINK: begin
        if (!is_head && !is_tail) begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
      end
      S_APPEND: begin
        lvl_we = 1'b1;
        if (nonempty_r[nlv_r]) begin
          next_we = 1'b1;
          next_wa = tail_r[nlv_r];
          next_wd = pid_r;
          prev_we = 1'b1;
          prev_wa = pid_r;
          prev_wd = tail_r[nlv_r];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (lvl_we)  lvl_mem[pid_r]    <= nlv_r;
    nx_rd_r <= next_mem[rd_addr];
    pv_rd_r <= prev_mem[rd_addr];
    lv_rd_r <= lvl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      queued_r    <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The final step loads the output register itself.
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            act_r    <= action_t'(in_action);
            pid_r    <= PID_W'(in_process_id);
            lv_r     <= LV_W'(in_priority_req);
            nlv_r    <= LV_W'(in_new_priority);
            pid_ok_r <= ({3'b000, in_process_id} < PID_LIM);
            lv_ok_r  <= ({1'b0, in_priority_req} < LV_LIM);
            nlv_ok_r <= ({1'b0, in_new_priority} < LV_LIM);
            got_r    <= '0;
            st_r     <= ST_OK;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          case (act_r)
            ACT_ENQ: begin
              nlv_r <= lv_r;
              if (!lv_ok_r || !pid_ok_r) begin
                st_r    <= ST_RANGE;
                state_r <= S_FIN;
              end else if (queued_r[pid_r]) begin
                st_r    <= ST_DUP;
                state_r <= S_FIN;
              end else begin
                state_r <= S_APPEND;
              end
            end
            ACT_DEQ_TOP, ACT_DEQ_LVL: begin
              if (act_r == ACT_DEQ_LVL && !lv_ok_r) begin
                st_r    <= ST_RANGE;
                state_r <= S_FIN;
              end else if (!nonempty_r[deq_lv]) begin
                st_r    <= ST_MISSING;
                state_r <= S_FIN;
              end else begin
                lv_r    <= deq_lv;
                pid_r   <= deq_head;
                got_r   <= deq_head;
                state_r <= S_UNLINK;
              end
            end
            default: begin
              if (!lv_ok_r || !nlv_ok_r) begin
                st_r    <= ST_RANGE;
                state_r <= S_FIN;
              end else if (!pid_ok_r || !queued_r[pid_r] || lv_rd_r != lv_r) begin
                st_r    <= ST_MISSING;
                state_r <= S_FIN;
              end else begin
                state_r <= S_UNLINK;
              end
            end
          endcase
        end
        S_UNLINK: begin
          queued_r[pid_r] <= 1'b0;
          if (is_head && is_tail) nonempty_r[lv_r] <= 1'b0;
          else if (is_head)       head_r[lv_r] <= nx_rd_r;
          else if (is_tail)       tail_r[lv_r] <= pv_rd_r;
          state_r <= (act_r == ACT_MOVE) ? S_APPEND : S_FIN;
        end
        S_APPEND: begin
          if (!nonempty_r[nlv_r]) head_r[nlv_r] <= pid_r;
          tail_r[nlv_r]     <= pid_r;
          nonempty_r[nlv_r] <= 1'b1;
          queued_r[pid_r]   <= 1'b1;
          state_r           <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pid_r   <= 4'(got_r);
            out_st_r    <= st_r;
            out_empty_r <= ~|nonempty_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/mrq_checker.sv]
// Port-level checker for the multilevel ready queue, bound to the core.
// Depends on mrq_pkg for status codes.
module mrq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_process_id,
  input mrq_pkg::status_t out_status,
  input logic       out_all_empty
);
  import mrq_pkg::*;

  // A stalled result holds still until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_process_id) &&
      $stable(out_status) && $stable(out_all_empty))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Only a successful dequeue reports an id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_process_id == 4'd0)
    else $error("id reported on a failed step");

  // A rejected duplicate means that id is still queued somewhere.
  a_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DUP |-> !out_all_empty)
    else $error("duplicate reported with every level empty");

endmodule

bind multilevel_ready_queue_core mrq_checker u_mrq_checker (.*);
